@@ design/mbc_pkg.sv @@
// Shared types and constants of the cache tag and replacement engine.
package mbc_pkg;

  localparam int MAX_SLOTS  = 256;
  localparam int STAMP_BITS = 32;
  localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
  localparam int COUNT_BITS = $clog2(MAX_SLOTS + 1);
  localparam int MIN_SLOTS  = 2;
  localparam int STAT_BITS  = 32;
  localparam int DISK_BITS  = 4;
  localparam int BLOCK_BITS = 8;
  localparam int CMD_BITS   = 2;
  localparam int STS_BITS   = 2;
  localparam int IDX_BITS   = 8;
  localparam int CFG_BITS   = 9;

  localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_UPDATE = 2'd2;

  localparam logic [STS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STS_BITS-1:0] ST_MISS = 2'd1;
  localparam logic [STS_BITS-1:0] ST_DUP  = 2'd2;
  localparam logic [STS_BITS-1:0] ST_OFF  = 2'd3;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  typedef struct packed {
    logic                  en;
    logic [SLOT_BITS-1:0]  idx;
    logic [DISK_BITS-1:0]  disk;
    logic [BLOCK_BITS-1:0] block;
    logic [STAMP_BITS-1:0] stamp;
  } slot_wr_t;

  typedef struct packed {
    logic                  valid;
    logic [DISK_BITS-1:0]  disk;
    logic [BLOCK_BITS-1:0] block;
    logic [STAMP_BITS-1:0] stamp;
  } slot_rd_t;

  typedef struct packed {
    logic                  clear_all;
    logic                  clear_above;
    logic [COUNT_BITS-1:0] limit;
  } slot_clr_t;

endpackage

@@ design/mbc_slot_store.sv @@
// Slot storage: valid flags in flops, tags and stamps in a one-port-read memory.
module mbc_slot_store (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [mbc_pkg::SLOT_BITS-1:0]        rd_addr,
  output mbc_pkg::slot_rd_t                    rd,
  input  mbc_pkg::slot_wr_t                    wr,
  input  mbc_pkg::slot_clr_t                   clr
);

  typedef struct packed {
    logic [mbc_pkg::DISK_BITS-1:0]  disk;
    logic [mbc_pkg::BLOCK_BITS-1:0] block;
    logic [mbc_pkg::STAMP_BITS-1:0] stamp;
  } entry_t;

  entry_t                        mem [mbc_pkg::MAX_SLOTS];
  logic [mbc_pkg::MAX_SLOTS-1:0] valid;
  entry_t                        rd_entry;
  logic                          rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= '{disk: wr.disk, block: wr.block, stamp: wr.stamp};
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      for (int i = 0; i < mbc_pkg::MAX_SLOTS; i++) begin
        if (clr.clear_all || (clr.clear_above &&
            (mbc_pkg::COUNT_BITS'(i) >= clr.limit))) begin
          valid[i] <= 1'b0;
        end
      end
      if (wr.en) begin
        valid[wr.idx] <= 1'b1;
      end
    end
  end

  assign rd.valid = rd_valid;
  assign rd.disk  = rd_entry.disk;
  assign rd.block = rd_entry.block;
  assign rd.stamp = rd_entry.stamp;

endmodule

@@ design/mru_block_cache_tag_engine_unit.sv @@
// Top level of the cache tag and replacement engine: scan sequencer and result port.
// Requests are taken one at a time: no new request is accepted until the previous result
// has been loaded into the output register. The scan reads one slot per cycle through the
// single read port of the slot memory; disabled or unused-code requests skip the scan.
// Reset: cache disabled, active_entries 256, all slots invalid, clock and counters zero.
// Slot tags and stamps in memory are not cleared; valid flags gate every read.
module mru_block_cache_tag_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // command[1:0], disk_id[5:2], block_id[13:6], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // status[1:0], slot_index[9:2], evicted[10],
                                 // hit_total[42:11], query_total[74:43], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t                              state;
  logic                                enable;
  logic [mbc_pkg::COUNT_BITS-1:0]      active;
  logic [mbc_pkg::STAMP_BITS-1:0]      access_clock;
  logic [mbc_pkg::STAT_BITS-1:0]       hit_counter;
  logic [mbc_pkg::STAT_BITS-1:0]       query_counter;
  logic [mbc_pkg::CMD_BITS-1:0]        cmd;
  logic [mbc_pkg::DISK_BITS-1:0]       key_disk;
  logic [mbc_pkg::BLOCK_BITS-1:0]      key_block;
  logic [mbc_pkg::COUNT_BITS-1:0]      addr;
  logic                                pend;
  logic [mbc_pkg::SLOT_BITS-1:0]       pend_idx;
  logic                                found_match;
  logic [mbc_pkg::SLOT_BITS-1:0]       match_idx;
  logic                                found_empty;
  logic [mbc_pkg::SLOT_BITS-1:0]       empty_idx;
  logic                                best_seen;
  logic [mbc_pkg::STAMP_BITS-1:0]      best_stamp;
  logic [mbc_pkg::SLOT_BITS-1:0]       best_idx;
  logic [mbc_pkg::STS_BITS-1:0]        res_status;
  logic [mbc_pkg::IDX_BITS-1:0]        res_slot;
  logic                                res_evicted;
  logic                                out_valid;
  logic [mbc_pkg::STS_BITS-1:0]        out_status;
  logic [mbc_pkg::IDX_BITS-1:0]        out_slot;
  logic                                out_evicted;
  logic [mbc_pkg::STAT_BITS-1:0]       out_hits;
  logic [mbc_pkg::STAT_BITS-1:0]       out_queries;

  logic [mbc_pkg::STAMP_BITS-1:0]      clock_next;
  logic [mbc_pkg::STAT_BITS-1:0]       hit_next;
  logic [mbc_pkg::STAT_BITS-1:0]       query_next;
  logic [mbc_pkg::STS_BITS-1:0]        status_next;
  logic [mbc_pkg::SLOT_BITS-1:0]       slot_next;
  logic                                evicted_next;
  logic [mbc_pkg::SLOT_BITS-1:0]       target;
  logic [mbc_pkg::COUNT_BITS-1:0]      cfg_count;
  logic                                s_fire;
  logic                                cfg_fire;
  logic                                key_hit;

  mbc_pkg::slot_rd_t                   rd;
  mbc_pkg::slot_wr_t                   wr;
  mbc_pkg::slot_clr_t                  clr;

  mbc_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (addr[mbc_pkg::SLOT_BITS-1:0]),
    .rd      (rd),
    .wr      (wr),
    .clr     (clr)
  );

  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign key_hit   = rd.valid && (rd.disk == key_disk) && (rd.block == key_block);

  always_comb begin
    if (cfg_data < mbc_pkg::CFG_BITS'(mbc_pkg::MIN_SLOTS)) begin
      cfg_count = mbc_pkg::COUNT_BITS'(mbc_pkg::MIN_SLOTS);
    end else if (cfg_data > mbc_pkg::CFG_BITS'(mbc_pkg::MAX_SLOTS)) begin
      cfg_count = mbc_pkg::COUNT_BITS'(mbc_pkg::MAX_SLOTS);
    end else begin
      cfg_count = mbc_pkg::COUNT_BITS'(cfg_data);
    end
    clr.clear_all   = cfg_fire && (cfg_index == mbc_pkg::REG_ENABLE);
    clr.clear_above = cfg_fire && (cfg_index == mbc_pkg::REG_ACTIVE);
    clr.limit       = cfg_count;
  end

  always_comb begin
    clock_next   = access_clock;
    hit_next     = hit_counter;
    query_next   = query_counter;
    status_next  = mbc_pkg::ST_MISS;
    slot_next    = '0;
    evicted_next = 1'b0;
    target       = found_empty ? empty_idx : best_idx;
    wr           = '0;
    wr.disk      = key_disk;
    wr.block     = key_block;
    if (!enable) begin
      status_next = mbc_pkg::ST_OFF;
    end else begin
      case (cmd)
        mbc_pkg::CMD_LOOKUP: begin
          query_next = query_counter + 1'b1;
          if (found_match) begin
            clock_next  = access_clock + 1'b1;
            hit_next    = hit_counter + 1'b1;
            wr.en       = 1'b1;
            wr.idx      = match_idx;
            wr.stamp    = clock_next;
            status_next = mbc_pkg::ST_OK;
            slot_next   = match_idx;
          end
        end
        mbc_pkg::CMD_INSERT: begin
          if (found_match) begin
            status_next = mbc_pkg::ST_DUP;
            slot_next   = match_idx;
          end else begin
            clock_next   = access_clock + 1'b1;
            wr.en        = 1'b1;
            wr.idx       = target;
            wr.stamp     = clock_next;
            status_next  = mbc_pkg::ST_OK;
            slot_next    = target;
            evicted_next = !found_empty;
          end
        end
        mbc_pkg::CMD_UPDATE: begin
          if (found_match) begin
            wr.en       = 1'b1;
            wr.idx      = match_idx;
            wr.stamp    = access_clock;
            status_next = mbc_pkg::ST_OK;
            slot_next   = match_idx;
          end
        end
        default: begin
        end
      endcase
    end
    wr.en = wr.en && (state == S_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      enable        <= 1'b0;
      active        <= mbc_pkg::COUNT_BITS'(mbc_pkg::MAX_SLOTS);
      access_clock  <= '0;
      hit_counter   <= '0;
      query_counter <= '0;
      pend          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_fire) begin
        if (cfg_index == mbc_pkg::REG_ENABLE) begin
          enable        <= cfg_data[0];
          access_clock  <= '0;
          hit_counter   <= '0;
          query_counter <= '0;
        end else begin
          active <= cfg_count;
        end
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            cmd         <= s_tdata[1:0];
            key_disk    <= s_tdata[5:2];
            key_block   <= s_tdata[13:6];
            addr        <= '0;
            pend        <= 1'b0;
            found_match <= 1'b0;
            found_empty <= 1'b0;
            best_seen   <= 1'b0;
            match_idx   <= '0;
            empty_idx   <= '0;
            best_idx    <= '0;
            if (enable && (s_tdata[1:0] == mbc_pkg::CMD_LOOKUP ||
                           s_tdata[1:0] == mbc_pkg::CMD_INSERT ||
                           s_tdata[1:0] == mbc_pkg::CMD_UPDATE)) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (addr < active) begin
            pend     <= 1'b1;
            pend_idx <= addr[mbc_pkg::SLOT_BITS-1:0];
            addr     <= addr + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (key_hit && !found_match) begin
              found_match <= 1'b1;
              match_idx   <= pend_idx;
            end
            if (!rd.valid && !found_empty) begin
              found_empty <= 1'b1;
              empty_idx   <= pend_idx;
            end
            if (!best_seen || (rd.stamp > best_stamp)) begin
              best_seen  <= 1'b1;
              best_stamp <= rd.stamp;
              best_idx   <= pend_idx;
            end
          end
          if ((addr == active) && !pend) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          access_clock  <= clock_next;
          hit_counter   <= hit_next;
          query_counter <= query_next;
          res_status    <= status_next;
          res_slot      <= mbc_pkg::IDX_BITS'(slot_next);
          res_evicted   <= evicted_next;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || m_tready) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_slot    <= res_slot;
            out_evicted <= res_evicted;
            out_hits    <= hit_counter;
            out_queries <= query_counter;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_queries, out_hits, out_evicted, out_slot, out_status};

  a_write_in_finish: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == S_FINISH))
    else $error("slot write outside finish step");

  a_clock_holds: assert property (@(posedge clk) disable iff (rst)
    ((state != S_FINISH) && !cfg_fire) |=> $stable(access_clock))
    else $error("access clock moved outside finish step");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (addr <= active))
    else $error("scan address past active count");

  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_evicted) |-> (out_status == mbc_pkg::ST_OK))
    else $error("eviction reported with failing status");

  a_off_quiet: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && !enable) |-> !wr.en)
    else $error("slot write while cache disabled");

endmodule

@@ sim/tb_mru_block_cache_tag_engine_unit.sv @@
// Self-checking testbench for the cache tag and MRU replacement engine.
module tb_mru_block_cache_tag_engine_unit;

  localparam int          ITEM_TARGET    = 1250;
  localparam int          QUIET_ITEMS    = 100;
  localparam int          DRAIN_CYCLES   = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;

  typedef struct packed {
    logic [mbc_pkg::STAT_BITS-1:0] query_total;
    logic [mbc_pkg::STAT_BITS-1:0] hit_total;
    logic                          evicted;
    logic [mbc_pkg::IDX_BITS-1:0]  slot_index;
    logic [mbc_pkg::STS_BITS-1:0]  status;
  } cache_resp_t;

  class tag_scoreboard;
    bit                             enabled;
    int unsigned                    active;
    bit                             slot_valid [mbc_pkg::MAX_SLOTS];
    logic [mbc_pkg::DISK_BITS-1:0]  slot_disk  [mbc_pkg::MAX_SLOTS];
    logic [mbc_pkg::BLOCK_BITS-1:0] slot_block [mbc_pkg::MAX_SLOTS];
    logic [mbc_pkg::STAMP_BITS-1:0] slot_stamp [mbc_pkg::MAX_SLOTS];
    logic [mbc_pkg::STAMP_BITS-1:0] clock_now;
    logic [mbc_pkg::STAT_BITS-1:0]  hits;
    logic [mbc_pkg::STAT_BITS-1:0]  queries;
    cache_resp_t                    expected_responses [$];
    int unsigned                    errors;
    int unsigned                    n_checked;

    function new();
      enabled   = 1'b0;
      active    = mbc_pkg::MAX_SLOTS;
      errors    = 0;
      n_checked = 0;
      clear_all();
    endfunction

    function void clear_all();
      int i;
      for (i = 0; i < mbc_pkg::MAX_SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_disk[i]  = '0;
        slot_block[i] = '0;
        slot_stamp[i] = '0;
      end
      clock_now = '0;
      hits      = '0;
      queries   = '0;
    endfunction

    function int find_tag(logic [mbc_pkg::DISK_BITS-1:0] disk,
                          logic [mbc_pkg::BLOCK_BITS-1:0] block);
      int i;
      for (i = 0; i < active; i++) begin
        if (slot_valid[i] && slot_disk[i] == disk && slot_block[i] == block) return i;
      end
      return -1;
    endfunction

    function void record_config(logic idx, logic [mbc_pkg::CFG_BITS-1:0] val);
      int unsigned v;
      int unsigned i;
      if (idx == mbc_pkg::REG_ENABLE) begin
        enabled = val[0];
        clear_all();
      end else begin
        v = 32'(val);
        if (v < mbc_pkg::MIN_SLOTS) v = mbc_pkg::MIN_SLOTS;
        if (v > mbc_pkg::MAX_SLOTS) v = mbc_pkg::MAX_SLOTS;
        active = v;
        for (i = v; i < mbc_pkg::MAX_SLOTS; i++) begin
          slot_valid[i] = 1'b0;
          slot_stamp[i] = '0;
        end
      end
    endfunction

    function void record_request(logic [15:0] req);
      cache_resp_t                    r;
      logic [mbc_pkg::CMD_BITS-1:0]   cmd;
      logic [mbc_pkg::DISK_BITS-1:0]  disk;
      logic [mbc_pkg::BLOCK_BITS-1:0] block;
      int                             match;
      int                             target;
      int                             i;
      cmd      = req[1:0];
      disk     = req[5:2];
      block    = req[13:6];
      r        = '0;
      r.status = mbc_pkg::ST_MISS;
      if (!enabled) begin
        r.status = mbc_pkg::ST_OFF;
      end else begin
        match = find_tag(disk, block);
        case (cmd)
          mbc_pkg::CMD_LOOKUP: begin
            queries++;
            if (match >= 0) begin
              clock_now++;
              slot_stamp[match] = clock_now;
              hits++;
              r.status     = mbc_pkg::ST_OK;
              r.slot_index = match[7:0];
            end
          end
          mbc_pkg::CMD_INSERT: begin
            if (match >= 0) begin
              r.status     = mbc_pkg::ST_DUP;
              r.slot_index = match[7:0];
            end else begin
              target = -1;
              for (i = 0; i < active; i++) begin
                if (!slot_valid[i]) begin
                  target = i;
                  break;
                end
              end
              if (target < 0) begin
                target = 0;
                for (i = 1; i < active; i++) begin
                  if (slot_stamp[i] > slot_stamp[target]) target = i;
                end
                r.evicted = 1'b1;
              end
              clock_now++;
              slot_valid[target] = 1'b1;
              slot_disk[target]  = disk;
              slot_block[target] = block;
              slot_stamp[target] = clock_now;
              r.status     = mbc_pkg::ST_OK;
              r.slot_index = target[7:0];
            end
          end
          mbc_pkg::CMD_UPDATE: begin
            if (match >= 0) begin
              slot_stamp[match] = clock_now;
              r.status     = mbc_pkg::ST_OK;
              r.slot_index = match[7:0];
            end
          end
          default: begin
          end
        endcase
      end
      r.hit_total   = hits;
      r.query_total = queries;
      expected_responses.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (errors < 100) $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_response(logic [79:0] data);
      cache_resp_t got;
      cache_resp_t want;
      got = data[74:0];
      n_checked++;
      if (expected_responses.size() == 0) begin
        report_mismatch("unexpected response", data[31:0], 32'd0);
      end else begin
        want = expected_responses.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.slot_index != want.slot_index)
          report_mismatch("slot_index", got.slot_index, want.slot_index);
        if (got.evicted != want.evicted) report_mismatch("evicted", got.evicted, want.evicted);
        if (got.hit_total != want.hit_total)
          report_mismatch("hit_total", got.hit_total, want.hit_total);
        if (got.query_total != want.query_total)
          report_mismatch("query_total", got.query_total, want.query_total);
      end
    endtask

    task check_leftover();
      if (expected_responses.size() != 0)
        report_mismatch("responses never seen", expected_responses.size(), 32'd0);
    endtask
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [79:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data  = '0;

  tag_scoreboard sb;
  int unsigned   n_sent     = 0;
  int unsigned   stall_left = 0;
  bit            quiet      = 1'b0;

  mru_block_cache_tag_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.record_config(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.record_request(s_tdata);
      if (m_tvalid && m_tready) sb.check_response(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 4);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_request(input logic [1:0] cmd, input logic [11:0] key);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, key[7:0], key[11:8], cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    if (n_sent >= ITEM_TARGET - QUIET_ITEMS) quiet <= 1'b1;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.n_checked != n_sent) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [8:0] val, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!hold) cfg_valid <= 1'b0;
  endtask

  task automatic configure(input bit wr_en, input logic [8:0] en_val,
                           input bit wr_act, input logic [8:0] act_val);
    wait_drained();
    if (wr_en) cfg_write(mbc_pkg::REG_ENABLE, en_val, wr_act);
    if (wr_act) cfg_write(mbc_pkg::REG_ACTIVE, act_val, 1'b0);
  endtask

  initial begin : stimulus
    logic [11:0] key_pool [40];
    logic [11:0] key;
    logic [11:0] base;
    logic [8:0]  act_val;
    logic [1:0]  cmd;
    int unsigned eff;
    int unsigned n_pool;
    int unsigned len;
    int unsigned pick;
    int unsigned r;
    int unsigned k;

    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // disabled after reset
    send_request(mbc_pkg::CMD_LOOKUP, 12'h000);
    send_request(mbc_pkg::CMD_INSERT, 12'hFFF);
    send_request(mbc_pkg::CMD_UPDATE, 12'hFFF);

    // two slots: fill, duplicate, hit, update, miss, unused code, evict on stamp tie
    configure(1'b1, 9'h1FF, 1'b1, 9'h000);
    send_request(mbc_pkg::CMD_LOOKUP, 12'h000);
    send_request(mbc_pkg::CMD_INSERT, 12'h000);
    send_request(mbc_pkg::CMD_INSERT, 12'hFFF);
    send_request(mbc_pkg::CMD_INSERT, 12'h000);
    send_request(mbc_pkg::CMD_LOOKUP, 12'hFFF);
    send_request(mbc_pkg::CMD_UPDATE, 12'h000);
    send_request(mbc_pkg::CMD_UPDATE, 12'h707);
    send_request(CMD_UNUSED, 12'hFFF);
    send_request(mbc_pkg::CMD_INSERT, 12'h309);
    send_request(mbc_pkg::CMD_LOOKUP, 12'h000);

    // grow with clamp above the slot count, contents kept
    configure(1'b0, 9'h000, 1'b1, 9'd511);
    send_request(mbc_pkg::CMD_LOOKUP, 12'hFFF);
    send_request(mbc_pkg::CMD_INSERT, 12'h000);
    send_request(mbc_pkg::CMD_UPDATE, 12'h309);
    configure(1'b0, 9'h000, 1'b1, 9'd257);
    send_request(mbc_pkg::CMD_LOOKUP, 12'h000);

    // shrink below minimum drops upper slots
    configure(1'b0, 9'h000, 1'b1, 9'd1);
    send_request(mbc_pkg::CMD_LOOKUP, 12'h000);
    send_request(mbc_pkg::CMD_INSERT, 12'h000);

    configure(1'b1, 9'h0FE, 1'b0, 9'h000);
    send_request(mbc_pkg::CMD_LOOKUP, 12'h309);
    send_request(mbc_pkg::CMD_INSERT, 12'h101);

    // fill every slot, then evict at full size
    configure(1'b1, 9'h001, 1'b1, 9'd256);
    base = 12'($urandom_range(0, 4095));
    for (k = 0; k < mbc_pkg::MAX_SLOTS + 2; k++)
      send_request(mbc_pkg::CMD_INSERT, base + k[11:0]);
    for (k = 0; k < 6; k++)
      send_request(mbc_pkg::CMD_LOOKUP, base + 12'($urandom_range(0, 257)));
    send_request(mbc_pkg::CMD_UPDATE, base + 12'd200);
    send_request(mbc_pkg::CMD_INSERT, base + 12'd300);

    while (n_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) act_val = 9'($urandom_range(0, 1));
      else if (pick == 1) act_val = 9'($urandom_range(255, 511));
      else act_val = 9'($urandom_range(2, 24));
      eff = 32'(act_val);
      if (eff < mbc_pkg::MIN_SLOTS) eff = mbc_pkg::MIN_SLOTS;
      if (eff > mbc_pkg::MAX_SLOTS) eff = mbc_pkg::MAX_SLOTS;
      if ($urandom_range(0, 3) != 0)
        configure(1'b1, {8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) != 0)},
                  1'b1, act_val);
      else
        configure(1'b0, 9'h000, 1'b1, act_val);
      len    = (pick == 1) ? $urandom_range(8, 16) : $urandom_range(20, 60);
      n_pool = eff + $urandom_range(1, 6);
      if (n_pool > 40) n_pool = 40;
      for (k = 0; k < n_pool; k++) key_pool[k] = 12'($urandom_range(0, 4095));
      for (k = 0; k < len && n_sent < ITEM_TARGET; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) cmd = mbc_pkg::CMD_LOOKUP;
        else if (r < 75) cmd = mbc_pkg::CMD_INSERT;
        else if (r < 95) cmd = mbc_pkg::CMD_UPDATE;
        else cmd = CMD_UNUSED;
        if ($urandom_range(0, 4) != 0) key = key_pool[$urandom_range(0, n_pool - 1)];
        else key = 12'($urandom_range(0, 4095));
        send_request(cmd, key);
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftover();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ mru_block_cache_tag_engine_unit.f @@
design/mbc_pkg.sv
design/mbc_slot_store.sv
design/mru_block_cache_tag_engine_unit.sv
sim/tb_mru_block_cache_tag_engine_unit.sv
